[hdl/vst_pkg.sv]
package vst_pkg;

   localparam int DATA_BITS = 8;
   localparam int OFFSET_BITS = 32;
   localparam int FIELD_BITS = 16;
   localparam int POSITION_BITS_DEFAULT = 32;
   localparam int LINE_BITS_DEFAULT = 16;
   localparam int KW_COUNT = 12;

   // Request kind carried on req_tuser
   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_END = 1'b1;

   typedef enum logic [4:0] {
      KIND_EOF       = 5'd0,
      KIND_IDENT     = 5'd1,
      KIND_NUMBER    = 5'd2,
      KIND_MODULE    = 5'd3,
      KIND_ENDMODULE = 5'd4,
      KIND_INPUT     = 5'd5,
      KIND_OUTPUT    = 5'd6,
      KIND_INOUT     = 5'd7,
      KIND_WIRE      = 5'd8,
      KIND_REG       = 5'd9,
      KIND_ASSIGN    = 5'd10,
      KIND_SIGNED    = 5'd11,
      KIND_ALWAYS    = 5'd12,
      KIND_BEGIN     = 5'd13,
      KIND_END       = 5'd14,
      KIND_OR_OR     = 5'd15,
      KIND_AND_AND   = 5'd16,
      KIND_EQ_EQ     = 5'd17,
      KIND_NOT_EQ    = 5'd18,
      KIND_LESS_EQ   = 5'd19,
      KIND_CHAR      = 5'd20
   } kind_type;

   typedef struct packed {
      kind_type                kind;
      logic [DATA_BITS-1:0]    code;
      logic [OFFSET_BITS-1:0]  offset;
      logic [FIELD_BITS-1:0]   length;
      logic [FIELD_BITS-1:0]   line;
      logic [FIELD_BITS-1:0]   column;
      logic                    last;
   } token_type;

   // Keyword text, right-aligned: character i sits at byte (len-1-i)
   localparam logic [71:0] KW_TEXT [KW_COUNT] = '{
      72'("module"), 72'("endmodule"), 72'("input"), 72'("output"),
      72'("inout"), 72'("wire"), 72'("reg"), 72'("assign"),
      72'("signed"), 72'("always"), 72'("begin"), 72'("end")
   };
   localparam logic [3:0] KW_LEN [KW_COUNT] = '{
      4'd6, 4'd9, 4'd5, 4'd6, 4'd5, 4'd4, 4'd3, 4'd6, 4'd6, 4'd6, 4'd5, 4'd3
   };

   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_BACKTICK  = 8'h60;
   localparam logic [7:0] CH_DOLLAR    = 8'h24;
   localparam logic [7:0] CH_QUOTE     = 8'h27;
   localparam logic [7:0] CH_UNDER     = 8'h5F;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_BAR       = 8'h7C;
   localparam logic [7:0] CH_AMP       = 8'h26;
   localparam logic [7:0] CH_EQUAL     = 8'h3D;
   localparam logic [7:0] CH_BANG      = 8'h21;
   localparam logic [7:0] CH_LESS      = 8'h3C;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_LPAREN    = 8'h28;
   localparam logic [7:0] CH_RPAREN    = 8'h29;
   localparam logic [7:0] CH_STAR      = 8'h2A;

   function automatic logic is_space(input logic [7:0] ch);
      return (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
   endfunction

   function automatic logic is_alpha(input logic [7:0] ch);
      return (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A);
   endfunction

   function automatic logic is_digit(input logic [7:0] ch);
      return ch >= 8'h30 && ch <= 8'h39;
   endfunction

   // Keywords whose character at position idx equals ch
   function automatic logic [KW_COUNT-1:0] kw_match(input logic [15:0] idx,
                                                    input logic [7:0] ch);
      logic [KW_COUNT-1:0] hit;
      logic [3:0]          sel;
      hit = '0;
      sel = '0;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (idx < 16'(KW_LEN[k])) begin
            sel = KW_LEN[k] - 4'd1 - idx[3:0];
            hit[k] = (KW_TEXT[k][8*sel +: 8] == ch);
         end
      end
      return hit;
   endfunction

endpackage

[hdl/verilog_subset_tokenizer.sv]
// Byte-serial lexer for a small Verilog subset. Each request is one source
// byte (req_tuser low) or an end-of-text mark (req_tuser high; a zero byte
// also ends the text). Tokens come out on the rsp_ channel with their kind,
// offset, length and starting line/column; rsp_tlast marks the final token
// caused by one request. A word, number or pending token is emitted when the
// byte after it arrives, so each request yields zero, one or two tokens.
// After the end-of-text token every request is taken and ignored until reset.
// Rate: one request per cycle while req_tready is high; a request is held in
// the input register, its tokens then go to a four-entry output queue that
// drains one token per cycle while rsp_tready is high. req_tready drops while
// a request waits in the input register and over two tokens are queued, so
// sustained throughput is set by the rsp_ side when requests produce two tokens.
module verilog_subset_tokenizer
   import vst_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT,
   parameter int LINE_BITS = LINE_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_value
   input  logic        req_tuser,   // [0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] char_code, [39:8] text_offset, [55:40] text_length,
   // [71:56] line_number, [87:72] start_column
   output logic [87:0] rsp_tdata,
   output logic [4:0]  rsp_tuser,   // [4:0] token_kind
   output logic        rsp_tlast
);

   localparam int QDEPTH = 4;
   localparam int QBITS = $clog2(QDEPTH);
   localparam int CBITS = $clog2(QDEPTH + 1);
   localparam logic [LINE_BITS-1:0] LINE_LIMIT =
      (LINE_BITS >= 16) ? LINE_BITS'(17'h0FFFF) : '1;
   localparam logic [15:0] LEN_MAX = 16'hFFFF;

   typedef enum logic [3:0] {
      MODE_IDLE, MODE_IDENT, MODE_ESC, MODE_NUM, MODE_PEND, MODE_LINE,
      MODE_BLK, MODE_BLK_STAR, MODE_ATT, MODE_ATT_STAR
   } mode_type;

   function automatic logic [OFFSET_BITS-1:0] pos_out(input logic [POSITION_BITS-1:0] p);
      return OFFSET_BITS'(p);
   endfunction

   function automatic logic [FIELD_BITS-1:0] line_out(input logic [LINE_BITS-1:0] v);
      return FIELD_BITS'(v);
   endfunction

   // input register
   logic                     in_valid_ff;
   logic [7:0]               in_byte_ff;
   logic                     in_func_ff;

   // lexer state
   mode_type                 mode_ff, mode_in;
   logic [7:0]               pend_ff, pend_in;
   logic [KW_COUNT-1:0]      alive_ff, alive_in;
   logic [15:0]              tlen_ff, tlen_in;
   logic [POSITION_BITS-1:0] tstart_ff, tstart_in;
   logic [LINE_BITS-1:0]     tline_ff, tline_in;
   logic [LINE_BITS-1:0]     tcol_ff, tcol_in;
   logic [POSITION_BITS-1:0] off_ff, off_in;
   logic [LINE_BITS-1:0]     line_ff, line_in;
   logic [LINE_BITS-1:0]     col_ff, col_in;
   logic                     done_ff, done_in;

   // output queue
   token_type                q_ff [QDEPTH];
   logic [QBITS-1:0]         head_ff, tail_ff;
   logic [CBITS-1:0]         count_ff;

   logic                     fire;
   logic                     pop;
   logic                     end_item;
   logic [7:0]               ch;
   logic                     flush_v;
   token_type                flush_tok;
   kind_type                 op_kind;
   logic                     op_hit;
   logic                     do_flush, do_idle, do_extend;
   logic                     slot_a_v, slot_b_v;
   token_type                slot_a, slot_b;
   token_type                tok0, tok1;
   logic [1:0]               n_res;

   assign fire = in_valid_ff && (count_ff <= CBITS'(QDEPTH - 2));
   assign req_tready = !in_valid_ff || fire;
   assign pop = rsp_tvalid && rsp_tready;
   assign ch = in_byte_ff;
   assign end_item = (in_func_ff == FUNC_END) || (in_byte_ff == 8'd0);

   // token in progress, as it would be emitted now
   always_comb begin
      kind_type kw;
      kw = KIND_IDENT;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (alive_ff[k] && tlen_ff == 16'(KW_LEN[k])) begin
            kw = kind_type'(5'(KIND_MODULE) + 5'(k));
         end
      end
      flush_v = mode_ff inside {MODE_IDENT, MODE_NUM, MODE_ESC, MODE_PEND};
      flush_tok = '{kind: KIND_IDENT, code: 8'd0, offset: pos_out(tstart_ff),
                    length: tlen_ff, line: line_out(tline_ff),
                    column: line_out(tcol_ff), last: 1'b0};
      case (mode_ff)
         MODE_IDENT: flush_tok.kind = kw;
         MODE_NUM:   flush_tok.kind = KIND_NUMBER;
         MODE_ESC:   flush_tok.offset = pos_out(tstart_ff + POSITION_BITS'(1));
         MODE_PEND: begin
            flush_tok.kind = KIND_CHAR;
            flush_tok.code = pend_ff;
            flush_tok.length = 16'd1;
         end
         default: ;
      endcase
   end

   always_comb begin
      op_hit = 1'b1;
      op_kind = KIND_OR_OR;
      if (pend_ff == CH_BAR && ch == CH_BAR) begin
         op_kind = KIND_OR_OR;
      end else if (pend_ff == CH_AMP && ch == CH_AMP) begin
         op_kind = KIND_AND_AND;
      end else if (pend_ff == CH_EQUAL && ch == CH_EQUAL) begin
         op_kind = KIND_EQ_EQ;
      end else if (pend_ff == CH_BANG && ch == CH_EQUAL) begin
         op_kind = KIND_NOT_EQ;
      end else if (pend_ff == CH_LESS && ch == CH_EQUAL) begin
         op_kind = KIND_LESS_EQ;
      end else begin
         op_hit = 1'b0;
      end
   end

   always_comb begin
      mode_in = mode_ff;
      pend_in = pend_ff;
      alive_in = alive_ff;
      tlen_in = tlen_ff;
      tstart_in = tstart_ff;
      tline_in = tline_ff;
      tcol_in = tcol_ff;
      off_in = off_ff;
      line_in = line_ff;
      col_in = col_ff;
      done_in = done_ff;
      do_flush = 1'b0;
      do_idle = 1'b0;
      do_extend = 1'b0;
      slot_a_v = 1'b0;
      slot_b_v = 1'b0;
      slot_a = flush_tok;
      slot_b = '{kind: KIND_EOF, code: 8'd0, offset: pos_out(off_ff),
                 length: 16'd0, line: line_out(line_ff),
                 column: line_out(col_ff), last: 1'b0};

      if (fire && !done_ff) begin
         if (end_item) begin
            do_flush = 1'b1;
            slot_b_v = 1'b1;
            done_in = 1'b1;
         end else begin
            case (mode_ff)
               MODE_IDENT: begin
                  if (is_alpha(ch) || is_digit(ch) || ch == CH_UNDER || ch == CH_DOLLAR) begin
                     do_extend = 1'b1;
                  end else begin
                     do_flush = 1'b1;
                     do_idle = 1'b1;
                  end
               end
               MODE_ESC: begin
                  if (!is_space(ch)) begin
                     do_extend = 1'b1;
                  end else begin
                     do_flush = 1'b1;
                     do_idle = 1'b1;
                  end
               end
               MODE_NUM: begin
                  if (is_alpha(ch) || is_digit(ch) || ch == CH_UNDER || ch == CH_QUOTE) begin
                     do_extend = 1'b1;
                  end else begin
                     do_flush = 1'b1;
                     do_idle = 1'b1;
                  end
               end
               MODE_PEND: begin
                  if (pend_ff == CH_SLASH && ch == CH_SLASH) begin
                     mode_in = MODE_LINE;
                  end else if (pend_ff == CH_SLASH && ch == CH_STAR) begin
                     mode_in = MODE_BLK;
                  end else if (pend_ff == CH_LPAREN && ch == CH_STAR) begin
                     mode_in = MODE_ATT;
                  end else if (op_hit) begin
                     slot_a_v = 1'b1;
                     slot_a.kind = op_kind;
                     slot_a.code = 8'd0;
                     slot_a.length = 16'd2;
                     mode_in = MODE_IDLE;
                  end else begin
                     do_flush = 1'b1;
                     do_idle = 1'b1;
                  end
               end
               MODE_LINE: begin
                  if (ch == CH_NEWLINE) begin
                     mode_in = MODE_IDLE;
                  end
               end
               MODE_BLK: begin
                  if (ch == CH_STAR) begin
                     mode_in = MODE_BLK_STAR;
                  end
               end
               MODE_BLK_STAR: begin
                  if (ch == CH_SLASH) begin
                     mode_in = MODE_IDLE;
                  end else if (ch != CH_STAR) begin
                     mode_in = MODE_BLK;
                  end
               end
               MODE_ATT: begin
                  if (ch == CH_STAR) begin
                     mode_in = MODE_ATT_STAR;
                  end
               end
               MODE_ATT_STAR: begin
                  if (ch == CH_RPAREN) begin
                     mode_in = MODE_IDLE;
                  end else if (ch != CH_STAR) begin
                     mode_in = MODE_ATT;
                  end
               end
               default: do_idle = 1'b1;
            endcase

            off_in = off_ff + POSITION_BITS'(1);
            if (ch == CH_NEWLINE) begin
               if (line_ff < LINE_LIMIT) begin
                  line_in = line_ff + LINE_BITS'(1);
               end
               col_in = LINE_BITS'(1);
            end else if (col_ff < LINE_LIMIT) begin
               col_in = col_ff + LINE_BITS'(1);
            end
         end
      end

      if (do_extend) begin
         if (tlen_ff != LEN_MAX) begin
            if (mode_ff == MODE_IDENT) begin
               alive_in = alive_ff & kw_match(tlen_ff, ch);
            end
            tlen_in = tlen_ff + 16'd1;
         end else begin
            alive_in = '0;
         end
      end

      if (do_flush) begin
         slot_a_v = flush_v;
         mode_in = MODE_IDLE;
      end

      if (do_idle) begin
         mode_in = MODE_IDLE;
         if (!is_space(ch)) begin
            if (ch == CH_BACKTICK) begin
               mode_in = MODE_LINE;
            end else if (ch == CH_BACKSLASH || is_alpha(ch) || is_digit(ch) ||
                         ch == CH_UNDER || ch == CH_DOLLAR || ch == CH_BAR ||
                         ch == CH_AMP || ch == CH_EQUAL || ch == CH_BANG ||
                         ch == CH_LESS || ch == CH_SLASH || ch == CH_LPAREN) begin
               tstart_in = off_ff;
               tline_in = line_ff;
               tcol_in = col_ff;
               tlen_in = 16'd1;
               if (is_alpha(ch) || ch == CH_UNDER || ch == CH_DOLLAR) begin
                  mode_in = MODE_IDENT;
                  alive_in = kw_match(16'd0, ch);
               end else if (ch == CH_BACKSLASH) begin
                  mode_in = MODE_ESC;
                  tlen_in = 16'd0;
               end else if (is_digit(ch)) begin
                  mode_in = MODE_NUM;
               end else begin
                  mode_in = MODE_PEND;
                  pend_in = ch;
               end
            end else begin
               slot_b_v = 1'b1;
               slot_b.kind = KIND_CHAR;
               slot_b.code = ch;
               slot_b.length = 16'd1;
            end
         end
      end
   end

   // pack up to two tokens, flush/operator first
   always_comb begin
      tok0 = slot_a;
      tok1 = slot_b;
      n_res = 2'd0;
      if (slot_a_v && slot_b_v) begin
         n_res = 2'd2;
      end else if (slot_a_v) begin
         n_res = 2'd1;
      end else if (slot_b_v) begin
         tok0 = slot_b;
         n_res = 2'd1;
      end
      tok0.last = (n_res == 2'd1);
      tok1.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff <= MODE_IDLE;
         pend_ff <= 8'd0;
         alive_ff <= '1;
         tlen_ff <= 16'd0;
         tstart_ff <= '0;
         tline_ff <= LINE_BITS'(1);
         tcol_ff <= LINE_BITS'(1);
         off_ff <= '0;
         line_ff <= LINE_BITS'(1);
         col_ff <= LINE_BITS'(1);
         done_ff <= 1'b0;
         head_ff <= '0;
         tail_ff <= '0;
         count_ff <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         mode_ff <= mode_in;
         pend_ff <= pend_in;
         alive_ff <= alive_in;
         tlen_ff <= tlen_in;
         tstart_ff <= tstart_in;
         tline_ff <= tline_in;
         tcol_ff <= tcol_in;
         off_ff <= off_in;
         line_ff <= line_in;
         col_ff <= col_in;
         done_ff <= done_in;
         if (pop) begin
            head_ff <= head_ff + QBITS'(1);
         end
         tail_ff <= tail_ff + QBITS'(n_res);
         count_ff <= count_ff + CBITS'(n_res) - CBITS'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_func_ff <= req_tuser;
      end
      if (n_res != 2'd0) begin
         q_ff[tail_ff] <= tok0;
      end
      if (n_res == 2'd2) begin
         q_ff[tail_ff + QBITS'(1)] <= tok1;
      end
   end

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tuser = q_ff[head_ff].kind;
   assign rsp_tlast = q_ff[head_ff].last;
   assign rsp_tdata = {q_ff[head_ff].column, q_ff[head_ff].line,
                       q_ff[head_ff].length, q_ff[head_ff].offset,
                       q_ff[head_ff].code};

`ifndef NO_ASSERTIONS
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CBITS'(QDEPTH))
      else $error("output queue overflow");

   a_quiet_after_eof: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> n_res == 2'd0)
      else $error("token produced after end of text");

   a_end_sets_done: assert property (@(posedge clock) disable iff (reset)
      fire && end_item |=> done_ff)
      else $error("end of text did not finish the stream");

   a_eof_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_EOF |-> rsp_tlast)
      else $error("eof token not marked last");

   a_position_nonzero: assert property (@(posedge clock) disable iff (reset)
      line_ff != '0 && col_ff != '0 && tline_ff != '0 && tcol_ff != '0)
      else $error("line or column counter reached zero");
`endif

endmodule

[dv/verilog_subset_tokenizer_checker.sv]
`timescale 1ns / 1ps

module verilog_subset_tokenizer_checker
   import vst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_value
   input  logic        req_tuser,   // [0] func
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] char_code, [39:8] text_offset, [55:40] text_length,
   // [71:56] line_number, [87:72] start_column
   input  logic [87:0] rsp_tdata,
   input  logic [4:0]  rsp_tuser,   // [4:0] token_kind
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          tokens_outstanding
);

   typedef enum logic [3:0] {
      SCAN_IDLE,
      SCAN_IDENT,
      SCAN_ESCAPED,
      SCAN_NUMBER,
      SCAN_PENDING,
      SCAN_LINE_COMMENT,
      SCAN_BLOCK,
      SCAN_BLOCK_STAR,
      SCAN_ATTR,
      SCAN_ATTR_STAR
   } scan_type;

   localparam logic [15:0] COUNT_MAX = 16'hFFFF;
   localparam logic [7:0]  CHAR_NUL = 8'h00;

   string keyword_text [KW_COUNT] = '{
      "module", "endmodule", "input", "output", "inout", "wire",
      "reg", "assign", "signed", "always", "begin", "end"
   };

   scan_type            mode;
   logic [7:0]          held_char;
   logic [KW_COUNT-1:0] kw_live;
   logic [15:0]         tok_len;
   logic [31:0]         tok_start;
   logic [15:0]         tok_line;
   logic [15:0]         tok_col;
   logic [31:0]         cur_offset;
   logic [15:0]         cur_line;
   logic [15:0]         cur_col;
   logic                ended;

   token_type           step_out [2];
   int                  step_count;
   token_type           expected_tokens [$];
   int                  mismatches = 0;

   function automatic logic char_space(input logic [7:0] ch);
      return ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR);
   endfunction

   function automatic logic char_letter(input logic [7:0] ch);
      return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
   endfunction

   function automatic logic char_digit(input logic [7:0] ch);
      return ch >= "0" && ch <= "9";
   endfunction

   function automatic void emit_token(input kind_type kind, input logic [7:0] code,
                                      input logic [31:0] offset, input logic [15:0] length,
                                      input logic [15:0] line, input logic [15:0] column);
      token_type t;
      t.kind   = kind;
      t.code   = code;
      t.offset = offset;
      t.length = length;
      t.line   = line;
      t.column = column;
      t.last   = 1'b0;
      step_out[step_count] = t;
      step_count++;
   endfunction

   // Drop every keyword whose character at idx differs from ch
   function automatic void match_keywords(input logic [7:0] ch, input logic [15:0] idx);
      for (int k = 0; k < KW_COUNT; k++) begin
         if (int'(idx) >= keyword_text[k].len() || keyword_text[k][int'(idx)] != ch)
            kw_live[k] = 1'b0;
      end
   endfunction

   function automatic void start_token(input scan_type next, input logic [15:0] length);
      mode      = next;
      tok_start = cur_offset;
      tok_line  = cur_line;
      tok_col   = cur_col;
      tok_len   = length;
   endfunction

   function automatic void grow_token(input logic [7:0] ch);
      if (tok_len != COUNT_MAX) begin
         if (mode == SCAN_IDENT)
            match_keywords(ch, tok_len);
         tok_len++;
      end else begin
         kw_live = '0;
      end
   endfunction

   function automatic void flush_token();
      kind_type kind;
      kind = KIND_IDENT;
      case (mode)
         SCAN_IDENT: begin
            for (int k = 0; k < KW_COUNT; k++)
               if (kw_live[k] && int'(tok_len) == keyword_text[k].len())
                  kind = kind_type'(int'(KIND_MODULE) + k);
            emit_token(kind, 8'h00, tok_start, tok_len, tok_line, tok_col);
         end
         SCAN_NUMBER:
            emit_token(KIND_NUMBER, 8'h00, tok_start, tok_len, tok_line, tok_col);
         SCAN_ESCAPED:
            // text starts after the backslash
            emit_token(KIND_IDENT, 8'h00, tok_start + 32'd1, tok_len, tok_line, tok_col);
         SCAN_PENDING:
            emit_token(KIND_CHAR, held_char, tok_start, 16'd1, tok_line, tok_col);
         default: ;
      endcase
      mode = SCAN_IDLE;
   endfunction

   function automatic void idle_char(input logic [7:0] ch);
      mode = SCAN_IDLE;
      if (char_space(ch)) begin
      end else if (ch == CH_BACKTICK) begin
         mode = SCAN_LINE_COMMENT;
      end else if (char_letter(ch) || ch == CH_UNDER || ch == CH_DOLLAR) begin
         start_token(SCAN_IDENT, 16'd1);
         kw_live = '1;
         match_keywords(ch, 16'd0);
      end else if (ch == CH_BACKSLASH) begin
         start_token(SCAN_ESCAPED, 16'd0);
      end else if (char_digit(ch)) begin
         start_token(SCAN_NUMBER, 16'd1);
      end else if (ch == CH_BAR || ch == CH_AMP || ch == CH_EQUAL || ch == CH_BANG ||
                   ch == CH_LESS || ch == CH_SLASH || ch == CH_LPAREN) begin
         start_token(SCAN_PENDING, 16'd1);
         held_char = ch;
      end else begin
         emit_token(KIND_CHAR, ch, cur_offset, 16'd1, cur_line, cur_col);
      end
   endfunction

   function automatic void resolve_pending(input logic [7:0] ch);
      kind_type kind;
      logic     pair;
      kind = KIND_CHAR;
      pair = 1'b1;
      if (held_char == CH_SLASH && ch == CH_SLASH) begin
         mode = SCAN_LINE_COMMENT;
      end else if (held_char == CH_SLASH && ch == CH_STAR) begin
         mode = SCAN_BLOCK;
      end else if (held_char == CH_LPAREN && ch == CH_STAR) begin
         mode = SCAN_ATTR;
      end else begin
         if (held_char == CH_BAR && ch == CH_BAR)         kind = KIND_OR_OR;
         else if (held_char == CH_AMP && ch == CH_AMP)    kind = KIND_AND_AND;
         else if (held_char == CH_EQUAL && ch == CH_EQUAL) kind = KIND_EQ_EQ;
         else if (held_char == CH_BANG && ch == CH_EQUAL)  kind = KIND_NOT_EQ;
         else if (held_char == CH_LESS && ch == CH_EQUAL)  kind = KIND_LESS_EQ;
         else pair = 1'b0;
         if (pair) begin
            emit_token(kind, 8'h00, tok_start, 16'd2, tok_line, tok_col);
            mode = SCAN_IDLE;
         end else begin
            flush_token();
            idle_char(ch);
         end
      end
   endfunction

   function automatic void predict_tokens(input logic func, input logic [7:0] ch);
      step_count = 0;
      if (!ended) begin
         if (func == FUNC_END || ch == CHAR_NUL) begin
            flush_token();
            emit_token(KIND_EOF, 8'h00, cur_offset, 16'd0, cur_line, cur_col);
            ended = 1'b1;
         end else begin
            case (mode)
               SCAN_IDENT:
                  if (char_letter(ch) || char_digit(ch) || ch == CH_UNDER || ch == CH_DOLLAR)
                     grow_token(ch);
                  else begin
                     flush_token();
                     idle_char(ch);
                  end
               SCAN_ESCAPED:
                  if (!char_space(ch))
                     grow_token(ch);
                  else begin
                     flush_token();
                     idle_char(ch);
                  end
               SCAN_NUMBER:
                  if (char_letter(ch) || char_digit(ch) || ch == CH_UNDER || ch == CH_QUOTE)
                     grow_token(ch);
                  else begin
                     flush_token();
                     idle_char(ch);
                  end
               SCAN_PENDING:
                  resolve_pending(ch);
               SCAN_LINE_COMMENT:
                  if (ch == CH_NEWLINE) mode = SCAN_IDLE;
               SCAN_BLOCK:
                  if (ch == CH_STAR) mode = SCAN_BLOCK_STAR;
               SCAN_BLOCK_STAR:
                  mode = (ch == CH_SLASH) ? SCAN_IDLE :
                         (ch == CH_STAR) ? SCAN_BLOCK_STAR : SCAN_BLOCK;
               SCAN_ATTR:
                  if (ch == CH_STAR) mode = SCAN_ATTR_STAR;
               SCAN_ATTR_STAR:
                  mode = (ch == CH_RPAREN) ? SCAN_IDLE :
                         (ch == CH_STAR) ? SCAN_ATTR_STAR : SCAN_ATTR;
               default:
                  idle_char(ch);
            endcase
            cur_offset++;
            if (ch == CH_NEWLINE) begin
               if (cur_line != COUNT_MAX) cur_line++;
               cur_col = 16'd1;
            end else if (cur_col != COUNT_MAX) begin
               cur_col++;
            end
         end
      end
      if (step_count > 0)
         step_out[step_count-1].last = 1'b1;
      for (int i = 0; i < step_count; i++)
         expected_tokens.push_back(step_out[i]);
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endfunction

   function automatic void check_token();
      token_type want;
      if (expected_tokens.size() == 0) begin
         $error("token_kind: expected none, actual %0d at offset %0d",
                rsp_tuser, rsp_tdata[39:8]);
         mismatches++;
      end else begin
         want = expected_tokens.pop_front();
         compare_field("token_kind", 32'(want.kind), 32'(rsp_tuser));
         compare_field("char_code", 32'(want.code), 32'(rsp_tdata[7:0]));
         compare_field("text_offset", want.offset, rsp_tdata[39:8]);
         compare_field("text_length", 32'(want.length), 32'(rsp_tdata[55:40]));
         compare_field("line_number", 32'(want.line), 32'(rsp_tdata[71:56]));
         compare_field("start_column", 32'(want.column), 32'(rsp_tdata[87:72]));
         compare_field("last", 32'(want.last), 32'(rsp_tlast));
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         mode       = SCAN_IDLE;
         held_char  = 8'h00;
         kw_live    = '1;
         tok_len    = 16'd0;
         tok_start  = 32'd0;
         tok_line   = 16'd1;
         tok_col    = 16'd1;
         cur_offset = 32'd0;
         cur_line   = 16'd1;
         cur_col    = 16'd1;
         ended      = 1'b0;
         expected_tokens.delete();
      end else begin
         if (req_tvalid && req_tready)
            predict_tokens(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready)
            check_token();
      end
      fail_count <= mismatches;
      tokens_outstanding <= expected_tokens.size();
   end

endmodule

[dv/verilog_subset_tokenizer_test.sv]
`timescale 1ns / 1ps

module verilog_subset_tokenizer_test
   import vst_pkg::*;
();

   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 1000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES = 16;
   localparam logic [7:0] CHAR_NUL = 8'h00;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tuser = FUNC_BYTE;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;
   logic [4:0]  rsp_tuser;
   logic        rsp_tlast;

   int          fail_count;
   int          tokens_outstanding;
   int          cycle_count = 0;
   int          burst_left = 0;
   bit          hold_off_req = 1'b0;
   logic [7:0]  text_bytes [$];

   string keyword_list [KW_COUNT] = '{
      "module", "endmodule", "input", "output", "inout", "wire",
      "reg", "assign", "signed", "always", "begin", "end"
   };

   always #4 clock = ~clock;

   verilog_subset_tokenizer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   verilog_subset_tokenizer_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_tvalid         (req_tvalid),
      .req_tready         (req_tready),
      .req_tdata          (req_tdata),
      .req_tuser          (req_tuser),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_tready         (rsp_tready),
      .rsp_tdata          (rsp_tdata),
      .rsp_tuser          (rsp_tuser),
      .rsp_tlast          (rsp_tlast),
      .fail_count         (fail_count),
      .tokens_outstanding (tokens_outstanding)
   );

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   // Token sink: stall pattern changes in phases; a hold-off request freezes it
   initial begin : token_sink
      int stall_pct;
      int phase_left;
      stall_pct = 0;
      phase_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end
         if (phase_left == 0) begin
            phase_left = $urandom_range(16, 96);
            case ($urandom_range(0, 3))
               0: stall_pct = 0;
               1: stall_pct = 25;
               2: stall_pct = 50;
               default: stall_pct = 85;
            endcase
         end
         phase_left--;
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   task automatic send_item(input logic func, input logic [7:0] value);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (burst_left > 0) burst_left--;
   endtask

   task automatic send_text();
      while (text_bytes.size() > 0)
         send_item(FUNC_BYTE, text_bytes.pop_front());
   endtask

   // Hold the sender until every predicted token has been seen
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tokens_outstanding != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] ident_char(input bit first);
      case ($urandom_range(0, first ? 5 : 7))
         0, 1, 2: return 8'("a" + $urandom_range(0, 25));
         3:       return 8'("A" + $urandom_range(0, 25));
         4:       return $urandom_range(0, 1) ? CH_UNDER : CH_DOLLAR;
         5:       return 8'("p" + $urandom_range(0, 10));
         default: return 8'("0" + $urandom_range(0, 9));
      endcase
   endfunction

   function automatic void add_space();
      repeat ($urandom_range(1, 3)) begin
         case ($urandom_range(0, 3))
            0:       text_bytes.push_back(CH_NEWLINE);
            1:       text_bytes.push_back(8'(CH_TAB + $urandom_range(0, 4)));
            default: text_bytes.push_back(CH_SPACE);
         endcase
      end
   endfunction

   function automatic void add_keyword();
      string w;
      int    cut;
      w = keyword_list[$urandom_range(0, KW_COUNT - 1)];
      cut = w.len();
      if ($urandom_range(0, 4) == 0) cut = $urandom_range(1, w.len());
      for (int i = 0; i < cut; i++) text_bytes.push_back(w[i]);
      if ($urandom_range(0, 4) == 0) text_bytes.push_back(ident_char(1'b0));
   endfunction

   function automatic void add_escaped();
      logic [7:0] ch;
      text_bytes.push_back(CH_BACKSLASH);
      repeat ($urandom_range(0, 6)) begin
         do ch = 8'($urandom_range(1, 255));
         while (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR));
         text_bytes.push_back(ch);
      end
   endfunction

   function automatic void add_number();
      text_bytes.push_back(8'("0" + $urandom_range(0, 9)));
      repeat ($urandom_range(0, 6))
         text_bytes.push_back($urandom_range(0, 3) == 0 ? CH_QUOTE : ident_char(1'b0));
   endfunction

   function automatic void add_operator();
      logic [7:0] lead;
      logic [7:0] partner;
      case ($urandom_range(0, 6))
         0: begin lead = CH_BAR;    partner = CH_BAR;    end
         1: begin lead = CH_AMP;    partner = CH_AMP;    end
         2: begin lead = CH_EQUAL;  partner = CH_EQUAL;  end
         3: begin lead = CH_BANG;   partner = CH_EQUAL;  end
         4: begin lead = CH_LESS;   partner = CH_EQUAL;  end
         5: begin lead = CH_SLASH;  partner = CH_SPACE;  end
         default: begin lead = CH_LPAREN; partner = CH_RPAREN; end
      endcase
      text_bytes.push_back(lead);
      case ($urandom_range(0, 3))
         0, 1: text_bytes.push_back(partner);
         2: begin
            case ($urandom_range(0, 5))
               0: text_bytes.push_back(CH_BAR);
               1: text_bytes.push_back(CH_AMP);
               2: text_bytes.push_back(CH_EQUAL);
               3: text_bytes.push_back(CH_LESS);
               4: text_bytes.push_back(CH_RPAREN);
               default: text_bytes.push_back(ident_char(1'b1));
            endcase
         end
         default: ;
      endcase
   endfunction

   function automatic logic [7:0] comment_char();
      case ($urandom_range(0, 9))
         0, 1, 2: return CH_STAR;
         3:       return CH_SLASH;
         4:       return CH_RPAREN;
         5:       return CH_NEWLINE;
         default: return 8'($urandom_range(1, 255));
      endcase
   endfunction

   function automatic void add_comment();
      case ($urandom_range(0, 3))
         0: begin
            text_bytes.push_back(CH_SLASH);
            text_bytes.push_back(CH_SLASH);
            repeat ($urandom_range(0, 8)) text_bytes.push_back(comment_char());
            text_bytes.push_back(CH_NEWLINE);
         end
         1: begin
            text_bytes.push_back(CH_BACKTICK);
            repeat ($urandom_range(1, 6)) text_bytes.push_back(ident_char(1'b1));
            text_bytes.push_back(CH_NEWLINE);
         end
         2: begin
            text_bytes.push_back(CH_SLASH);
            text_bytes.push_back(CH_STAR);
            repeat ($urandom_range(0, 8)) text_bytes.push_back(comment_char());
            text_bytes.push_back(CH_STAR);
            text_bytes.push_back(CH_SLASH);
         end
         default: begin
            text_bytes.push_back(CH_LPAREN);
            text_bytes.push_back(CH_STAR);
            repeat ($urandom_range(0, 8)) text_bytes.push_back(comment_char());
            text_bytes.push_back(CH_STAR);
            text_bytes.push_back(CH_RPAREN);
         end
      endcase
   endfunction

   function automatic void add_word();
      case ($urandom_range(0, 10))
         0, 1, 2: add_keyword();
         3, 4: begin
            text_bytes.push_back(ident_char(1'b1));
            repeat ($urandom_range(0, 10)) text_bytes.push_back(ident_char(1'b0));
         end
         5: add_escaped();
         6: add_number();
         7, 8: add_operator();
         9: add_comment();
         default: repeat ($urandom_range(1, 3)) text_bytes.push_back(8'($urandom_range(1, 255)));
      endcase
      if ($urandom_range(0, 9) < 6 || text_bytes[0] == CH_BACKSLASH)
         add_space();
   endfunction

   initial begin : stimulus
      string directed;
      int    random_sent;
      bit    mid_pause_done;
      directed = "\\e 4'b1||&&==!=<=(*)x*)/**/$a";
      random_sent = 0;
      mid_pause_done = 1'b0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < directed.len(); i++) text_bytes.push_back(directed[i]);
      text_bytes.push_back(8'hFF);
      text_bytes.push_back(8'h01);
      text_bytes.push_back(CH_BACKTICK);
      text_bytes.push_back("q");
      text_bytes.push_back(CH_NEWLINE);
      send_text();
      wait_drained();

      // sink freezes while requests keep coming, so the block backs up
      hold_off_req = 1'b1;
      while (random_sent < RANDOM_ITEMS) begin
         if (random_sent >= RANDOM_ITEMS / 2 && !mid_pause_done) begin
            wait_drained();
            hold_off_req = 1'b1;
            mid_pause_done = 1'b1;
         end
         add_word();
         random_sent += text_bytes.size();
         send_text();
      end
      wait_drained();

      repeat (20) add_word();
      send_text();

      // sometimes leave something open when the text ends
      case ($urandom_range(0, 3))
         1: text_bytes.push_back("x");
         2: text_bytes.push_back(CH_LESS);
         3: begin
            text_bytes.push_back(CH_SLASH);
            text_bytes.push_back(CH_STAR);
            text_bytes.push_back("q");
         end
         default: ;
      endcase
      send_text();
      if ($urandom_range(0, 1)) begin
         send_item(FUNC_END, 8'($urandom_range(0, 255)));
         send_item(FUNC_BYTE, CHAR_NUL);
      end else begin
         send_item(FUNC_BYTE, CHAR_NUL);
         send_item(FUNC_END, 8'hFF);
      end
      // ignored after end of text
      send_item(FUNC_BYTE, "a");
      send_item(FUNC_END, CHAR_NUL);
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (tokens_outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && tokens_outstanding == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
